>>> src/utf8_lossy_sanitizer_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef UTF8_LOSSY_SANITIZER_UNIT_MACROS_SVH
`define UTF8_LOSSY_SANITIZER_UNIT_MACROS_SVH

// Property checked only while reset is released.
`define USU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define USU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/usu_pkg.sv
// Types, constants and helpers shared by the front end, back end and top level.
package usu_pkg;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [1:0] SUB_B0 = 2'd0;
    localparam logic [1:0] SUB_B1 = 2'd1;
    localparam logic [1:0] SUB_B2 = 2'd2;

    localparam int MAX_TOKENS = 4;

    // One input beat worth of output: up to four tokens, each a literal byte
    // or a three-byte replacement.
    typedef struct packed {
        logic [2:0]                  n;
        logic [MAX_TOKENS-1:0]       repl;
        logic [MAX_TOKENS-1:0][7:0]  bytes;
        logic                        eos;
    } t_cmd;

    function automatic logic [7:0] repl_byte(input logic [1:0] sub);
        logic [7:0] b;
        unique case (sub)
            SUB_B0:  b = REPL_B0;
            SUB_B1:  b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

endpackage

>>> src/usu_fifo.sv
// Small register queue carrying commands from the front end to the back end.
module usu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> src/usu_front.sv
// Front end: validates each input byte against the pending sequence and
// builds the token list for it.
module usu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    input  logic          i_full,
    output logic          o_push,
    output usu_pkg::t_cmd o_cmd
);
    import usu_pkg::*;

    logic [2:0][7:0] r_pend, n_pend;
    logic [1:0]      r_cnt, n_cnt;
    logic [2:0]      r_exp, n_exp;
    logic            accept;
    t_cmd            cmd;

    function automatic t_cmd add_tok(input t_cmd c, input logic r, input logic [7:0] b);
        t_cmd o;
        o = c;
        o.repl[c.n[1:0]]  = r;
        o.bytes[c.n[1:0]] = b;
        o.n               = c.n + 3'd1;
        return o;
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b >= 8'hC2 && b <= 8'hDF) begin
            len = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            len = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic ok;
        priority if (lead == 8'hE0) begin
            ok = (b >= 8'hA0) && (b <= 8'hBF);
        end else if (lead == 8'hED) begin
            ok = (b >= 8'h80) && (b <= 8'h9F);
        end else if (lead == 8'hF0) begin
            ok = (b >= 8'h90) && (b <= 8'hBF);
        end else if (lead == 8'hF4) begin
            ok = (b >= 8'h80) && (b <= 8'h8F);
        end else begin
            ok = (b[7:6] == 2'b10);
        end
        return ok;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (cmd.n != 3'd0);
    assign o_cmd   = cmd;

    always_comb begin
        logic       ok;
        logic       do_start;
        logic [2:0] len;
        cmd      = '0;
        cmd.eos  = i_eos;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        do_start = 1'b0;
        len      = lead_len(i_byte);
        ok       = (r_cnt == 2'd1) ? second_ok(r_pend[0], i_byte) : (i_byte[7:6] == 2'b10);

        if (r_cnt == 2'd0) begin
            do_start = 1'b1;
        end else if (ok) begin
            if (({1'b0, r_cnt} + 3'd1) >= r_exp) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_cnt) begin
                        cmd = add_tok(cmd, 1'b0, r_pend[i]);
                    end
                end
                cmd   = add_tok(cmd, 1'b0, i_byte);
                n_cnt = 2'd0;
                n_exp = 3'd0;
            end else begin
                if (r_cnt == 2'd1) begin
                    n_pend[1] = i_byte;
                end else begin
                    n_pend[2] = i_byte;
                end
                n_cnt = r_cnt + 2'd1;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < r_cnt) begin
                    cmd = add_tok(cmd, 1'b1, 8'h00);
                end
            end
            n_cnt    = 2'd0;
            n_exp    = 3'd0;
            do_start = 1'b1;
        end

        if (do_start) begin
            if (!i_byte[7]) begin
                cmd = add_tok(cmd, 1'b0, i_byte);
            end else if (len != 3'd0) begin
                n_pend[0] = i_byte;
                n_cnt     = 2'd1;
                n_exp     = len;
            end else begin
                cmd = add_tok(cmd, 1'b1, 8'h00);
            end
        end

        if (i_eos) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_cnt) begin
                    cmd = add_tok(cmd, 1'b1, 8'h00);
                end
            end
            n_cnt = 2'd0;
            n_exp = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_exp <= 3'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

>>> src/usu_back.sv
// Back end: expands queued tokens into output beats through an output register.
module usu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  usu_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_run_last,
    output logic          o_string_last
);
    import usu_pkg::*;

    logic [1:0] r_tok, n_tok;
    logic [1:0] r_sub, n_sub;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_string_last;
    logic       load, take, is_repl, tok_end, last;
    logic [7:0] cur_byte;

    assign load     = !r_valid || i_ready;
    assign take     = load && !i_empty;
    assign is_repl  = i_cmd.repl[r_tok];
    assign cur_byte = is_repl ? repl_byte(r_sub) : i_cmd.bytes[r_tok];
    assign tok_end  = !is_repl || (r_sub == SUB_B2);
    assign last     = tok_end && (({1'b0, r_tok} + 3'd1) == i_cmd.n);
    assign o_pop    = take && last;

    always_comb begin
        n_tok = r_tok;
        n_sub = r_sub;
        if (take) begin
            if (tok_end) begin
                n_sub = SUB_B0;
                n_tok = last ? 2'd0 : r_tok + 2'd1;
            end else begin
                n_sub = r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 2'd0;
            r_sub   <= SUB_B0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_sub <= n_sub;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte        <= cur_byte;
            r_run_last    <= last;
            r_string_last <= last && i_cmd.eos;
        end
    end

    assign o_valid       = r_valid;
    assign o_byte        = r_byte;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_string_last;

endmodule

>>> src/utf8_lossy_sanitizer_unit.sv
// Streaming UTF-8 sanitizer: passes well-formed sequences, replaces malformed
// bytes with EF BF BD, and flushes held bytes as replacements at string end.
// One input byte is accepted per cycle while the command queue has room; the
// output register delivers one byte per cycle while the receiver is ready, so
// an input beat that yields 0 to 12 output bytes holds the output for all of
// them, and the input keeps flowing until QUEUE_DEPTH such commands are waiting.
// Output passes the command queue and output register. Bytes that only extend
// a pending sequence produce no output until the sequence completes or breaks.
// QUEUE_DEPTH must be a power of two from 2 to 16.
module utf8_lossy_sanitizer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // end_of_string
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // run_last
    output logic [0:0] o_m_axis_tuser    // [0] string_last
);
    import usu_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    t_cmd             front_cmd;
    logic             push, pop, full, empty;
    logic [CMD_W-1:0] head_raw;
    logic             string_last;

    usu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_eos   (i_s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    usu_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_raw),
        .o_empty (empty)
    );

    usu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (t_cmd'(head_raw)),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_byte        (o_m_axis_tdata),
        .o_run_last    (o_m_axis_tlast),
        .o_string_last (string_last)
    );

    assign o_m_axis_tuser = string_last;

endmodule

>>> src/usu_checker.sv
// Port-level checks for the sanitizer and their binding to the top level.
`include "utf8_lossy_sanitizer_unit_macros.svh"

module usu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic [0:0] o_m_axis_tuser
);

    logic in_beat;
    logic stalled;

    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;

    // accepted input beat carries known data
    `USU_ASSERT(a_in_known, i_clk, i_rst_n, in_beat |-> !$isunknown({i_s_axis_tdata, i_s_axis_tlast}), "input beat with unknown data")

    // stalled output beat holds
    `USU_ASSERT(a_out_hold, i_clk, i_rst_n, stalled |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser)), "output beat changed while stalled")

    // end of string is always the end of a run
    `USU_ASSERT(a_str_run, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast, "string_last without run_last")

    // a run never ends on a lead byte
    `USU_ASSERT(a_run_end, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata[7:6] != 2'b11), "run ends on a lead byte")

    // input is ready and output is idle right after reset
    `USU_ASSERT_ALWAYS(a_rst_state, i_clk, !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid), "not idle after reset")

endmodule

bind utf8_lossy_sanitizer_unit usu_checker u_usu_checker (.*);

>>> dv/utf8_lossy_sanitizer_unit_test.sv
// Self-checking testbench for the streaming UTF-8 sanitizer with a byte-level predictor.
`timescale 1ns / 1ps

module utf8_lossy_sanitizer_unit_test;
    import usu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 125;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_DIRECTED  = 24;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
    } t_utf8_beat;

    class sanitizer_scoreboard;
        logic [7:0]  held_bytes [3];
        int unsigned held_cnt;
        int unsigned seq_len;
        logic [7:0]  step_out [$];
        t_utf8_beat  expected_q [$];
        int unsigned mismatches;
        int unsigned beats_in;
        int unsigned beats_out;
        int unsigned strings;
        int unsigned replacements;

        function new();
            held_cnt     = 0;
            seq_len      = 0;
            mismatches   = 0;
            beats_in     = 0;
            beats_out    = 0;
            strings      = 0;
            replacements = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR: %s", msg);
        endtask

        function void push_replacement();
            replacements++;
            step_out.push_back(REPL_B0);
            step_out.push_back(REPL_B1);
            step_out.push_back(REPL_B2);
        endfunction

        function void flush_held();
            for (int i = 0; i < held_cnt; i++)
                push_replacement();
            held_cnt = 0;
            seq_len  = 0;
        endfunction

        function void start_seq(logic [7:0] b);
            int unsigned len;
            len = 0;
            if (b < 8'h80) begin
                step_out.push_back(b);
                return;
            end
            if (b >= 8'hC2 && b <= 8'hDF)
                len = 2;
            else if (b >= 8'hE0 && b <= 8'hEF)
                len = 3;
            else if (b >= 8'hF0 && b <= 8'hF4)
                len = 4;
            if (len == 0) begin
                push_replacement();
                return;
            end
            held_bytes[0] = b;
            held_cnt      = 1;
            seq_len       = len;
        endfunction

        function bit second_ok(logic [7:0] lead, logic [7:0] b);
            case (lead)
                8'hE0:   return b >= 8'hA0 && b <= 8'hBF;
                8'hED:   return b >= 8'h80 && b <= 8'h9F;
                8'hF0:   return b >= 8'h90 && b <= 8'hBF;
                8'hF4:   return b >= 8'h80 && b <= 8'h8F;
                default: return b[7:6] == 2'b10;
            endcase
        endfunction

        function void note_input(logic [7:0] b, logic eos);
            bit         ok;
            t_utf8_beat beat;
            beats_in++;
            step_out.delete();
            if (held_cnt == 0) begin
                start_seq(b);
            end else begin
                ok = (held_cnt == 1) ? second_ok(held_bytes[0], b) : (b[7:6] == 2'b10);
                if (ok && held_cnt + 1 >= seq_len) begin
                    for (int i = 0; i < held_cnt; i++)
                        step_out.push_back(held_bytes[i]);
                    step_out.push_back(b);
                    held_cnt = 0;
                    seq_len  = 0;
                end else if (ok) begin
                    held_bytes[held_cnt] = b;
                    held_cnt++;
                end else begin
                    flush_held();
                    start_seq(b);
                end
            end
            if (eos) begin
                flush_held();
                strings++;
            end
            foreach (step_out[k]) begin
                beat.data    = step_out[k];
                beat.run_end = (k == step_out.size() - 1);
                beat.str_end = beat.run_end && eos;
                expected_q.push_back(beat);
            end
        endfunction

        task check_output(logic [7:0] data, logic run_end, logic str_end);
            t_utf8_beat want;
            beats_out++;
            if (expected_q.size() == 0) begin
                report($sformatf("output beat %02h with nothing expected", data));
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data)
                report($sformatf("beat %0d: byte %02h, expected %02h",
                                 beats_out, data, want.data));
            if (run_end !== want.run_end)
                report($sformatf("beat %0d: tlast %b, expected %b",
                                 beats_out, run_end, want.run_end));
            if (str_end !== want.str_end)
                report($sformatf("beat %0d: tuser %b, expected %b",
                                 beats_out, str_end, want.str_end));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_last;
    logic [0:0] m_user;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         cycles = 0;
    logic [7:0] str_bytes [$];

    sanitizer_scoreboard sb = new();

    // {eos, byte}
    logic [8:0] directed_seq [NUM_DIRECTED] = '{
        9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0FF,
        9'h0C2, 9'h080,
        9'h0DF, 9'h1BF,
        9'h0E0, 9'h09F,
        9'h0E0, 9'h0A0, 9'h0BF,
        9'h0ED, 9'h09F, 9'h080,
        9'h0F0, 9'h08F,
        9'h0F4, 9'h08F, 9'h0BF, 9'h1C3,
        9'h1E0
    };

    utf8_lossy_sanitizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] in_byte
        .i_s_axis_tlast  (s_last),   // end_of_string
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] out_byte
        .o_m_axis_tlast  (m_last),   // run_last
        .o_m_axis_tuser  (m_user)    // [0] string_last
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (m_valid && m_ready)
                sb.check_output(m_data, m_last, m_user[0]);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eos;
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        sb.note_input(b, eos);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    function automatic void push_valid_seq();
        logic [7:0] lead;
        case ($urandom_range(3))
            0: str_bytes.push_back(8'($urandom_range(127)));
            1: begin
                str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                str_bytes.push_back(rand_cont());
            end
            2: begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                str_bytes.push_back(lead);
                if (lead == 8'hE0)
                    str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                else if (lead == 8'hED)
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                else
                    str_bytes.push_back(rand_cont());
                str_bytes.push_back(rand_cont());
            end
            default: begin
                lead = 8'($urandom_range(8'hF0, 8'hF4));
                str_bytes.push_back(lead);
                if (lead == 8'hF0)
                    str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                else if (lead == 8'hF4)
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                else
                    str_bytes.push_back(rand_cont());
                str_bytes.push_back(rand_cont());
                str_bytes.push_back(rand_cont());
            end
        endcase
    endfunction

    // strict-lead second byte that is a continuation but out of range
    function automatic void push_strict_violation();
        case ($urandom_range(3))
            0: begin
                str_bytes.push_back(8'hE0);
                str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
            end
            1: begin
                str_bytes.push_back(8'hED);
                str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
            end
            2: begin
                str_bytes.push_back(8'hF0);
                str_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
            end
            default: begin
                str_bytes.push_back(8'hF4);
                str_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
            end
        endcase
    endfunction

    function automatic void build_string();
        int r;
        int len0;
        str_bytes.delete();
        repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(99);
            if (r < 70) begin
                push_valid_seq();
            end else if (r < 80) begin
                str_bytes.push_back(8'($urandom_range(255)));
            end else if (r < 90) begin
                len0 = str_bytes.size();
                push_valid_seq();
                if (str_bytes.size() - len0 > 1)
                    void'(str_bytes.pop_back());
            end else begin
                push_strict_violation();
            end
        end
    endfunction

    task automatic send_string();
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_seq[i])
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_string();
                send_string();
                sent += str_bytes.size();
            end
            wait_drained();
        end

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d output beats never arrived", sb.expected_q.size()));
        $display("Sent %0d input beats in %0d strings, checked %0d output beats",
                 sb.beats_in, sb.strings, sb.beats_out);
        $display("(%0d replacements) across four sender/receiver idling phases.",
                 sb.replacements);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
